>>> hdl/tlbat_pkg.sv
package tlbat_pkg;

    localparam int TLB_ENTRIES    = 2;
    localparam int SLOT_BITS      = $clog2(TLB_ENTRIES);
    localparam int ADDR_BITS      = 16;
    localparam int DATA_BITS      = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    // request modes
    localparam logic [1:0] MODE_READ       = 2'd0;
    localparam logic [1:0] MODE_WRITE      = 2'd1;
    localparam logic [1:0] MODE_TABLE_WORD = 2'd2;
    localparam logic [1:0] MODE_NONE       = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_READ       = 2'd0;
    localparam logic [1:0] KIND_WRITE      = 2'd1;
    localparam logic [1:0] KIND_TABLE_READ = 2'd2;
    localparam logic [1:0] KIND_REFUSED    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRANSLATE_ENABLE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAGE_TABLE_BASE  = 1'd1;

    typedef struct packed {
        logic [1:0]                  mode;
        logic [ADDR_BITS-1:0]        virtual_address;
        logic signed [DATA_BITS-1:0] store_data;
        logic [DATA_BITS-1:0]        table_word;
    } request_t;

    typedef struct packed {
        logic [1:0]                  request_kind;
        logic [ADDR_BITS-1:0]        memory_address;
        logic signed [DATA_BITS-1:0] write_value;
        logic                        tlb_hit;
    } result_t;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
    } lookup_t;

endpackage

>>> hdl/tlbat_lookup.sv
module tlbat_lookup #(
    parameter int PAGE_BITS = 6
) (
    input  logic [tlbat_pkg::TLB_ENTRIES-1:0][PAGE_BITS-1:0] entry_page,
    input  logic [tlbat_pkg::TLB_ENTRIES-1:0]                entry_valid,
    input  logic [PAGE_BITS-1:0]                             page,
    output tlbat_pkg::lookup_t                               lookup
);

    // all entries compared in parallel; the lowest matching slot wins
    always_comb
    begin
        lookup = '0;
        for (int i = tlbat_pkg::TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (entry_valid[i] && (entry_page[i] == page))
            begin
                lookup.hit  = 1'b1;
                lookup.slot = tlbat_pkg::SLOT_BITS'(i);
            end
        end
    end

endmodule

>>> hdl/tlb_address_translator_core.sv
// Channel    Ports                                Handshake
// request    start, busy, request                 taken when start & !busy
// result     done, result                         one-cycle strobe, no backpressure
// config     cfg_we, cfg_index, cfg_data          written when cfg_we
//
// One request per cycle; busy stays low. The request is registered, then the
// TLB compare, fill and result select run combinationally into the result
// register, so the input and result registers lie between a request and its strobe.
// Reset clears the valid bits, the replace pointer and the pending miss.
// The receiver cannot stall; a miss holds its access until the table word arrives.
module tlb_address_translator_core #(
    parameter int PAGE_BITS   = 6,
    parameter int OFFSET_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  tlbat_pkg::request_t                   request,
    output logic                                  done,
    output tlbat_pkg::result_t                    result,
    input  logic                                  cfg_we,
    input  logic [tlbat_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tlbat_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int ENTRIES = tlbat_pkg::TLB_ENTRIES;
    localparam int WIDE    = 2 * tlbat_pkg::DATA_BITS;

    logic                                   translate_enable_reg;
    logic [tlbat_pkg::ADDR_BITS-1:0]        page_table_base_reg;

    logic                                   in_valid_reg;
    tlbat_pkg::request_t                    in_reg;

    logic [ENTRIES-1:0][PAGE_BITS-1:0]      entry_page_reg, entry_page_next;
    logic [ENTRIES-1:0][PAGE_BITS-1:0]      entry_frame_reg, entry_frame_next;
    logic [ENTRIES-1:0]                     entry_valid_reg, entry_valid_next;
    logic [tlbat_pkg::SLOT_BITS-1:0]        replace_ptr_reg, replace_ptr_next;
    logic                                   pending_reg, pending_next;
    logic [PAGE_BITS-1:0]                   held_page_reg, held_page_next;
    logic [OFFSET_BITS-1:0]                 held_offset_reg, held_offset_next;
    logic                                   held_is_write_reg, held_is_write_next;
    logic signed [tlbat_pkg::DATA_BITS-1:0] held_data_reg, held_data_next;

    logic                                   done_reg, done_next;
    tlbat_pkg::result_t                     result_reg, result_next;

    logic [WIDE-1:0]                        va_shifted;
    logic [PAGE_BITS-1:0]                   page;
    logic [OFFSET_BITS-1:0]                 offset;
    logic [PAGE_BITS-1:0]                   fill_frame;
    tlbat_pkg::lookup_t                     lookup;
    logic [WIDE-1:0]                        hit_addr_wide;
    logic [WIDE-1:0]                        fill_addr_wide;
    logic [WIDE-1:0]                        table_addr_wide;
    logic signed [tlbat_pkg::DATA_BITS-1:0] data_out;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            translate_enable_reg <= 1'b0;
            page_table_base_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tlbat_pkg::REG_TRANSLATE_ENABLE: translate_enable_reg <= cfg_data[0];
                tlbat_pkg::REG_PAGE_TABLE_BASE:  page_table_base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            in_reg <= request;
    end

    assign va_shifted = WIDE'(in_reg.virtual_address) >> OFFSET_BITS;
    assign page       = va_shifted[PAGE_BITS-1:0];
    assign offset     = in_reg.virtual_address[OFFSET_BITS-1:0];
    assign fill_frame = in_reg.table_word[PAGE_BITS-1:0];
    assign data_out   = (in_reg.mode == tlbat_pkg::MODE_WRITE) ? in_reg.store_data : '0;

    tlbat_lookup #(
        .PAGE_BITS (PAGE_BITS)
    ) u_lookup (
        .entry_page  (entry_page_reg),
        .entry_valid (entry_valid_reg),
        .page        (page),
        .lookup      (lookup)
    );

    assign hit_addr_wide   = (WIDE'(entry_frame_reg[lookup.slot]) << OFFSET_BITS)
                             | WIDE'(offset);
    assign fill_addr_wide  = (WIDE'(fill_frame) << OFFSET_BITS) | WIDE'(held_offset_reg);
    assign table_addr_wide = WIDE'(page_table_base_reg) + (WIDE'(page) << 2);

    always_comb
    begin
        entry_page_next    = entry_page_reg;
        entry_frame_next   = entry_frame_reg;
        entry_valid_next   = entry_valid_reg;
        replace_ptr_next   = replace_ptr_reg;
        pending_next       = pending_reg;
        held_page_next     = held_page_reg;
        held_offset_next   = held_offset_reg;
        held_is_write_next = held_is_write_reg;
        held_data_next     = held_data_reg;
        done_next          = 1'b0;
        result_next        = '0;

        if (in_valid_reg)
        begin
            unique case (in_reg.mode)
                tlbat_pkg::MODE_TABLE_WORD:
                begin
                    if (pending_reg)
                    begin
                        entry_page_next[replace_ptr_reg]  = held_page_reg;
                        entry_frame_next[replace_ptr_reg] = fill_frame;
                        entry_valid_next[replace_ptr_reg] = 1'b1;
                        replace_ptr_next = replace_ptr_reg + 1'b1;
                        pending_next     = 1'b0;
                        done_next        = 1'b1;
                        result_next.request_kind   = held_is_write_reg ?
                                                     tlbat_pkg::KIND_WRITE :
                                                     tlbat_pkg::KIND_READ;
                        result_next.memory_address = fill_addr_wide[tlbat_pkg::ADDR_BITS-1:0];
                        result_next.write_value    = held_is_write_reg ? held_data_reg : '0;
                    end
                end
                tlbat_pkg::MODE_READ, tlbat_pkg::MODE_WRITE:
                begin
                    done_next = 1'b1;
                    priority if (pending_reg)
                    begin
                        result_next.request_kind = tlbat_pkg::KIND_REFUSED;
                    end
                    else if (!translate_enable_reg)
                    begin
                        result_next.request_kind   = in_reg.mode;
                        result_next.memory_address = in_reg.virtual_address;
                        result_next.write_value    = data_out;
                    end
                    else if (lookup.hit)
                    begin
                        result_next.request_kind   = in_reg.mode;
                        result_next.memory_address =
                            hit_addr_wide[tlbat_pkg::ADDR_BITS-1:0];
                        result_next.write_value    = data_out;
                        result_next.tlb_hit        = 1'b1;
                    end
                    else
                    begin
                        // miss: park the access and fetch the table entry
                        pending_next       = 1'b1;
                        held_page_next     = page;
                        held_offset_next   = offset;
                        held_is_write_next = (in_reg.mode == tlbat_pkg::MODE_WRITE);
                        held_data_next     = data_out;
                        result_next.request_kind   = tlbat_pkg::KIND_TABLE_READ;
                        result_next.memory_address =
                            table_addr_wide[tlbat_pkg::ADDR_BITS-1:0];
                    end
                end
                tlbat_pkg::MODE_NONE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            replace_ptr_reg <= '0;
            pending_reg     <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            replace_ptr_reg <= replace_ptr_next;
            pending_reg     <= pending_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_page_reg    <= entry_page_next;
        entry_frame_reg   <= entry_frame_next;
        held_page_reg     <= held_page_next;
        held_offset_reg   <= held_offset_next;
        held_is_write_reg <= held_is_write_next;
        held_data_reg     <= held_data_next;
        result_reg        <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // a refused access only while a miss was outstanding
    a_refused_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (result_reg.request_kind == tlbat_pkg::KIND_REFUSED) |-> pending_reg)
        else $error("refused request without a pending miss");

    // a table read always leaves a miss outstanding
    a_table_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (result_reg.request_kind == tlbat_pkg::KIND_TABLE_READ) |-> pending_reg)
        else $error("table read issued but no miss pending");

    a_hit_needs_translate: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.tlb_hit |-> $past(translate_enable_reg))
        else $error("TLB hit reported with translation off");

    // entries are only ever replaced, never invalidated
    a_valid_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(entry_valid_reg) & ~entry_valid_reg) == '0)
        else $error("TLB entry lost its valid bit");

endmodule
